>>> hdl/bsm_pkg.sv
// shared constants and types of the stack machine execute unit
package bsm_pkg;

    // default sizes
    localparam int STACK_DEPTH_DEF    = 1024;
    localparam int CODE_ADDR_BITS_DEF = 16;

    // field widths
    localparam int OPC_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 32;
    localparam int ENTRY_W = 16;

    // opcodes
    localparam logic [OPC_W-1:0] OP_GET   = 4'd0;
    localparam logic [OPC_W-1:0] OP_SET   = 4'd1;
    localparam logic [OPC_W-1:0] OP_SUB1  = 4'd2;
    localparam logic [OPC_W-1:0] OP_RET   = 4'd3;
    localparam logic [OPC_W-1:0] OP_CALL  = 4'd4;
    localparam logic [OPC_W-1:0] OP_JMP   = 4'd5;
    localparam logic [OPC_W-1:0] OP_JGT   = 4'd6;
    localparam logic [OPC_W-1:0] OP_PUSH  = 4'd7;
    localparam logic [OPC_W-1:0] OP_POP   = 4'd8;
    localparam logic [OPC_W-1:0] OP_DUMP  = 4'd9;
    localparam logic [OPC_W-1:0] OP_HALT  = 4'd10;

    // sequencer states
    typedef enum logic [2:0] {
        ST_ISSUE  = 3'b001,
        ST_READ   = 3'b010,
        ST_FINISH = 3'b100
    } seq_state_t;

endpackage

>>> hdl/bytecode_stack_machine_execute_core.sv
// execute unit of a small stack bytecode machine, built around one slot memory
//
// Each input item is one fetched instruction (opcode and the byte after it); each
// item yields exactly one result item with the next fetch address, the halted and
// fault flags and, for debug, three stack slots. The stack lives in a synchronous
// slot memory with one write port and one read port whose data is registered.
// Instructions run one after another: jmp, call, push, pop, halt,
// unassigned codes, any faulting instruction and any step of a stopped machine
// read no slot; get, set and sub1 read one, ret and jgt two, and debug three. The
// memory read port returns one slot per cycle, and
// the write of each instruction lands in its last cycle, before the next
// instruction issues its first read, so no forwarding path is needed. An input
// register takes the next item while the current one executes, and an output
// register holds a finished result while the sequencer goes on. Until the first
// item is accepted after reset, writes of the entry address move the program
// counter. The slot memory is not cleared; reading a slot never written is
// undefined. Code addresses wrap at CODE_ADDR_BITS bits.
module bytecode_stack_machine_execute_core #(
    parameter int STACK_DEPTH    = bsm_pkg::STACK_DEPTH_DEF,
    parameter int CODE_ADDR_BITS = bsm_pkg::CODE_ADDR_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // configuration
    input  logic                            cfg_write_en,
    input  logic [bsm_pkg::ENTRY_W-1:0]     cfg_write_data,

    // instruction items
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [bsm_pkg::OPC_W-1:0]       req_opcode,
    input  logic [bsm_pkg::BYTE_W-1:0]      operand_byte,

    // result items
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [CODE_ADDR_BITS-1:0]       next_fetch_address,
    output logic                            halted_flag,
    output logic                            fault_flag,
    output logic                            debug_valid,
    output logic signed [bsm_pkg::SLOT_W-1:0] debug_slot_one,
    output logic signed [bsm_pkg::SLOT_W-1:0] debug_slot_two,
    output logic signed [bsm_pkg::SLOT_W-1:0] debug_slot_three
);

    localparam int AW   = $clog2(STACK_DEPTH);      // slot address
    localparam int TW   = $clog2(STACK_DEPTH + 1);  // top index, holds the depth itself
    localparam int SW   = TW + bsm_pkg::BYTE_W + 1; // room for top + byte + small constant
    localparam int CAW  = CODE_ADDR_BITS;
    localparam int DW   = bsm_pkg::SLOT_W;

    localparam logic [SW-1:0] DEPTH_W = SW'(STACK_DEPTH);

    // slot memory
    logic [DW-1:0] slot_mem [STACK_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [DW-1:0] mem_rdata_reg;

    // input register
    logic                          in_full_reg;
    logic [bsm_pkg::OPC_W-1:0]     in_opcode_reg;
    logic [bsm_pkg::BYTE_W-1:0]    in_operand_reg;

    // architectural state
    logic [CAW-1:0] pc_reg;
    logic [TW-1:0]  top_reg;
    logic           stopped_reg;
    logic           not_started_reg;

    // sequencer
    bsm_pkg::seq_state_t           state_reg, state_next;
    logic [bsm_pkg::OPC_W-1:0]     op_reg;
    logic [bsm_pkg::BYTE_W-1:0]    operand_reg;
    logic [AW-1:0]                 base_reg;
    logic [1:0]                    nreads_reg;
    logic [1:0]                    rd_idx_reg;
    logic [DW-1:0]                 d0_reg;
    logic [DW-1:0]                 d1_reg;

    // output register
    logic           out_valid_reg;
    logic [CAW-1:0] out_next_reg;
    logic           out_halted_reg;
    logic           out_fault_reg;
    logic           out_dbg_reg;
    logic [DW-1:0]  out_d1_reg;
    logic [DW-1:0]  out_d2_reg;
    logic [DW-1:0]  out_d3_reg;

    // handshake helpers
    logic out_free;
    logic consume;
    logic in_accept;
    logic finish_now;

    // decode and execute
    logic [bsm_pkg::OPC_W-1:0]  cur_op;
    logic [bsm_pkg::BYTE_W-1:0] cur_n;
    logic [SW-1:0]              top_w;
    logic [SW-1:0]              n_w;
    logic [CAW-1:0]             p_seq1;
    logic [CAW-1:0]             p_seq2;
    logic [CAW-1:0]             p_branch;
    logic                       ex_fault;
    logic [1:0]                 ex_nreads;
    logic [SW-1:0]              ex_base;
    logic [TW-1:0]              ex_top;
    logic [CAW-1:0]             ex_pc;
    logic                       ex_we;
    logic [SW-1:0]              ex_waddr;
    logic [DW-1:0]              ex_wdata;
    logic                       ex_halt;
    logic                       ex_dbg;

    assign out_free   = !out_valid_reg || !out_stall;
    assign consume    = (state_reg == bsm_pkg::ST_ISSUE) && in_full_reg && out_free;
    assign in_stall   = in_full_reg && !consume;
    assign in_accept  = in_valid && !in_stall;

    // a result is produced at issue when nothing has to be read, else after the reads
    assign finish_now = (consume && (stopped_reg || ex_nreads == 2'd0))
                     || ((state_reg == bsm_pkg::ST_FINISH) && out_free);

    // the instruction in flight: straight from the input register at issue
    assign cur_op = (state_reg == bsm_pkg::ST_ISSUE) ? in_opcode_reg : op_reg;
    assign cur_n  = (state_reg == bsm_pkg::ST_ISSUE) ? in_operand_reg : operand_reg;

    assign top_w    = SW'(top_reg);
    assign n_w      = SW'(cur_n);
    assign p_seq1   = pc_reg + CAW'(1);
    assign p_seq2   = pc_reg + CAW'(2);
    // branch offset counts from the operand byte
    assign p_branch = pc_reg + CAW'(1) + CAW'($signed(cur_n));

    // per-opcode bounds check, read plan and final effect; at finish the last read
    // word is on mem_rdata_reg and earlier ones sit in d0_reg and d1_reg
    always_comb
    begin
        ex_fault  = 1'b0;
        ex_nreads = 2'd0;
        ex_base   = top_w;
        ex_top    = top_reg;
        ex_pc     = p_seq1;
        ex_we     = 1'b0;
        ex_waddr  = top_w;
        ex_wdata  = mem_rdata_reg;
        ex_halt   = 1'b0;
        ex_dbg    = 1'b0;
        case (cur_op)
            bsm_pkg::OP_GET:
            begin
                ex_pc = p_seq2;
                if (top_w + n_w >= DEPTH_W || top_reg == '0)
                begin
                    ex_fault = 1'b1;
                end
                else
                begin
                    ex_nreads = 2'd1;
                    ex_base   = top_w + n_w;
                    ex_we     = 1'b1;
                    ex_waddr  = top_w - SW'(1);
                    ex_top    = top_reg - TW'(1);
                end
            end
            bsm_pkg::OP_SET:
            begin
                ex_pc = p_seq2;
                if (top_w + SW'(1) + n_w >= DEPTH_W)
                begin
                    ex_fault = 1'b1;
                end
                else
                begin
                    ex_nreads = 2'd1;
                    ex_we     = 1'b1;
                    ex_waddr  = top_w + SW'(1) + n_w;
                    ex_top    = top_reg + TW'(1);
                end
            end
            bsm_pkg::OP_SUB1:
            begin
                if (top_w >= DEPTH_W)
                begin
                    ex_fault = 1'b1;
                end
                else
                begin
                    ex_nreads = 2'd1;
                    ex_we     = 1'b1;
                    ex_wdata  = mem_rdata_reg - DW'(1);
                end
            end
            bsm_pkg::OP_RET:
            begin
                ex_pc = p_seq2;
                if (top_w + SW'(1) + n_w >= DEPTH_W)
                begin
                    ex_fault = 1'b1;
                end
                else
                begin
                    // d0 is the return value, the second word the return address
                    ex_nreads = 2'd2;
                    ex_we     = 1'b1;
                    ex_waddr  = top_w + SW'(1) + n_w;
                    ex_wdata  = d0_reg;
                    ex_top    = TW'(top_w + SW'(1) + n_w);
                    ex_pc     = mem_rdata_reg[CAW-1:0];
                end
            end
            bsm_pkg::OP_CALL:
            begin
                ex_pc = p_seq2;
                if (top_reg == '0)
                begin
                    ex_fault = 1'b1;
                end
                else
                begin
                    ex_we    = 1'b1;
                    ex_waddr = top_w - SW'(1);
                    ex_wdata = DW'(p_seq2);
                    ex_top   = top_reg - TW'(1);
                    ex_pc    = p_branch;
                end
            end
            bsm_pkg::OP_JMP:
            begin
                ex_pc = p_branch;
            end
            bsm_pkg::OP_JGT:
            begin
                ex_pc = p_seq2;
                if (top_w + SW'(1) >= DEPTH_W)
                begin
                    ex_fault = 1'b1;
                end
                else
                begin
                    ex_nreads = 2'd2;
                    ex_top    = top_reg + TW'(2);
                    if ($signed(d0_reg) > $signed(mem_rdata_reg))
                    begin
                        ex_pc = p_branch;
                    end
                end
            end
            bsm_pkg::OP_PUSH:
            begin
                ex_pc = p_seq2;
                if (top_reg == '0)
                begin
                    ex_fault = 1'b1;
                end
                else
                begin
                    ex_we    = 1'b1;
                    ex_waddr = top_w - SW'(1);
                    ex_wdata = DW'(cur_n);
                    ex_top   = top_reg - TW'(1);
                end
            end
            bsm_pkg::OP_POP:
            begin
                if (top_w >= DEPTH_W)
                begin
                    ex_fault = 1'b1;
                end
                else
                begin
                    ex_top = top_reg + TW'(1);
                end
            end
            bsm_pkg::OP_DUMP:
            begin
                if (top_w + SW'(3) >= DEPTH_W)
                begin
                    ex_fault = 1'b1;
                end
                else
                begin
                    ex_nreads = 2'd3;
                    ex_base   = top_w + SW'(1);
                    ex_dbg    = 1'b1;
                end
            end
            bsm_pkg::OP_HALT:
            begin
                ex_pc   = pc_reg;
                ex_halt = 1'b1;
            end
            default:
            begin
                ex_pc = p_seq1;
            end
        endcase
    end

    // memory port control
    always_comb
    begin
        mem_we    = finish_now && !stopped_reg && ex_we;
        mem_waddr = ex_waddr[AW-1:0];
        mem_wdata = ex_wdata;
        mem_re    = 1'b0;
        mem_raddr = base_reg + AW'(rd_idx_reg);
        if (state_reg == bsm_pkg::ST_ISSUE)
        begin
            mem_re    = consume && !stopped_reg && (ex_nreads != 2'd0);
            mem_raddr = ex_base[AW-1:0];
        end
        else if (state_reg == bsm_pkg::ST_READ)
        begin
            mem_re = 1'b1;
        end
    end

    // read data holds while the read port is idle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= slot_mem[mem_raddr];
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bsm_pkg::ST_ISSUE:
            begin
                if (consume && !stopped_reg && ex_nreads != 2'd0)
                begin
                    state_next = (ex_nreads == 2'd1) ? bsm_pkg::ST_FINISH : bsm_pkg::ST_READ;
                end
            end
            bsm_pkg::ST_READ:
            begin
                if (rd_idx_reg + 2'd1 == nreads_reg)
                begin
                    state_next = bsm_pkg::ST_FINISH;
                end
            end
            bsm_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = bsm_pkg::ST_ISSUE;
                end
            end
            default:
            begin
                state_next = bsm_pkg::ST_ISSUE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= bsm_pkg::ST_ISSUE;
            in_full_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            pc_reg          <= '0;
            top_reg         <= TW'(STACK_DEPTH);
            stopped_reg     <= 1'b0;
            not_started_reg <= 1'b1;
            rd_idx_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // entry address moves the pc only before the first item
            if (cfg_write_en && not_started_reg)
            begin
                pc_reg <= CAW'(cfg_write_data);
            end

            if (in_accept)
            begin
                in_full_reg     <= 1'b1;
                not_started_reg <= 1'b0;
            end
            else if (consume)
            begin
                in_full_reg <= 1'b0;
            end

            if (consume)
            begin
                rd_idx_reg <= 2'd1;
            end
            else if (state_reg == bsm_pkg::ST_READ)
            begin
                rd_idx_reg <= rd_idx_reg + 2'd1;
            end

            if (finish_now)
            begin
                out_valid_reg <= 1'b1;
                if (!stopped_reg)
                begin
                    pc_reg  <= ex_pc;
                    top_reg <= ex_top;
                    if (ex_halt)
                    begin
                        stopped_reg <= 1'b1;
                    end
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_opcode_reg  <= req_opcode;
            in_operand_reg <= operand_byte;
        end

        if (consume)
        begin
            op_reg      <= in_opcode_reg;
            operand_reg <= in_operand_reg;
            base_reg    <= ex_base[AW-1:0];
            nreads_reg  <= ex_nreads;
        end

        // capture the earlier read words of a multi-read instruction
        if (state_reg == bsm_pkg::ST_READ)
        begin
            if (rd_idx_reg == 2'd1)
            begin
                d0_reg <= mem_rdata_reg;
            end
            else
            begin
                d1_reg <= mem_rdata_reg;
            end
        end

        if (finish_now)
        begin
            if (stopped_reg)
            begin
                out_next_reg   <= pc_reg;
                out_halted_reg <= 1'b1;
                out_fault_reg  <= 1'b0;
                out_dbg_reg    <= 1'b0;
                out_d1_reg     <= '0;
                out_d2_reg     <= '0;
                out_d3_reg     <= '0;
            end
            else
            begin
                out_next_reg   <= ex_pc;
                out_halted_reg <= ex_halt;
                out_fault_reg  <= ex_fault;
                out_dbg_reg    <= ex_dbg;
                out_d1_reg     <= ex_dbg ? d0_reg : '0;
                out_d2_reg     <= ex_dbg ? d1_reg : '0;
                out_d3_reg     <= ex_dbg ? mem_rdata_reg : '0;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign next_fetch_address = out_next_reg;
    assign halted_flag        = out_halted_reg;
    assign fault_flag         = out_fault_reg;
    assign debug_valid        = out_dbg_reg;
    assign debug_slot_one     = $signed(out_d1_reg);
    assign debug_slot_two     = $signed(out_d2_reg);
    assign debug_slot_three   = $signed(out_d3_reg);

endmodule
